### sv/agst_pkg.sv
// shared types, constants and gear tables for the automatic gearbox
// used by agst_div and auto_gearbox_shift_and_torque; no dependencies
package agst_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_MODE = 1'd1;

    // shared divider geometry (radix-4, two quotient bits per step)
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 15;
    localparam int DIV_STEP_W = 5;

    // steps per division, sized from the largest dividend of each use
    localparam logic [DIV_STEP_W-1:0] STEPS_22B = 5'd11;
    localparam logic [DIV_STEP_W-1:0] STEPS_24B = 5'd12;
    localparam logic [DIV_STEP_W-1:0] STEPS_20B = 5'd10;
    localparam logic [DIV_STEP_W-1:0] STEPS_42B = 5'd21;
    localparam logic [DIV_STEP_W-1:0] STEPS_48B = 5'd24;

    localparam logic [DIV_DEN_W-1:0] DEN_PCT = 15'd100;
    localparam logic [DIV_DEN_W-1:0] DEN_SQ = 15'd10000;

    localparam logic [7:0] PCT_SCALE = 8'd100;
    localparam logic [7:0] LUG_GAIN = 8'd99;
    localparam logic [7:0] FALL_GAIN = 8'd45;

    localparam logic [16:0] ACCEL_OUT_MAX = 17'd104856;
    localparam logic [23:0] BAND_FULL = 24'd100;
    // band at or above this always saturates a nonzero base
    localparam logic [23:0] BAND_MAX = 24'hFFFFFF;
    // ratio at or above this always gives a band beyond BAND_MAX
    localparam logic [19:0] RATIO_MAX = 20'hFFFFF;
    localparam logic [19:0] RATIO_SMALL = 20'd99;

    localparam logic [2:0] GEAR_REV = 3'd0;
    localparam logic [2:0] GEAR_FIRST = 3'd1;
    localparam logic [2:0] GEAR_TOP = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHK,
        ST_UP_MUL,
        ST_UP_DIV,
        ST_DN_MUL,
        ST_DN_DIV,
        ST_TOP_MUL,
        ST_TOP_DIV,
        ST_BOT_MUL,
        ST_BOT_DIV,
        ST_BAND,
        ST_RAT_MUL,
        ST_RAT_DIV,
        ST_SQ_MUL,
        ST_SQ2_MUL,
        ST_SQ_DIV,
        ST_LIN_MUL,
        ST_LIN_DIV,
        ST_BASE_MUL,
        ST_BASE_DIV,
        ST_BB_MUL,
        ST_BB_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
        logic [DIV_NUM_W-1:0]  num;
        logic [DIV_DEN_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } t_div_rsp;

    // gear tables, indexed by gear 1..5
    function automatic logic [7:0] f_top_pct(input logic [2:0] g);
        logic [7:0] v;
        case (g)
            3'd1: v = 8'd22;
            3'd2: v = 8'd40;
            3'd3: v = 8'd60;
            3'd4: v = 8'd80;
            3'd5: v = 8'd100;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] f_torque_pct(input logic [2:0] g);
        logic [7:0] v;
        case (g)
            3'd1: v = 8'd160;
            3'd2: v = 8'd130;
            3'd3: v = 8'd100;
            3'd4: v = 8'd75;
            3'd5: v = 8'd55;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] f_up_pct(input logic [2:0] g);
        logic [7:0] v;
        case (g)
            3'd1: v = 8'd20;
            3'd2: v = 8'd38;
            3'd3: v = 8'd57;
            3'd4: v = 8'd76;
            3'd5: v = 8'd100;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] f_down_pct(input logic [2:0] g);
        logic [7:0] v;
        case (g)
            3'd1: v = 8'd0;
            3'd2: v = 8'd8;
            3'd3: v = 8'd18;
            3'd4: v = 8'd35;
            3'd5: v = 8'd52;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

### sv/agst_div.sv
// shared unsigned radix-4 divider, two quotient bits per cycle
// depends on agst_pkg for the request and response structs
module agst_div
    import agst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0]  r_rem;
    logic [DIV_DEN_W-1:0]  r_den;
    logic [DIV_NUM_W-1:0]  r_num;
    logic [DIV_NUM_W-1:0]  r_quo;

    logic [1:0]             pair;
    logic [DIV_DEN_W+1:0]   part;
    logic [DIV_DEN_W+1:0]   d1;
    logic [DIV_DEN_W+1:0]   d2;
    logic [DIV_DEN_W+1:0]   d3;
    logic [1:0]             digit;
    logic [DIV_DEN_W+1:0]   rem_full;

    assign pair = r_num[{r_cnt, 1'b0} +: 2];
    assign part = {r_rem, pair};
    assign d1 = {2'b00, r_den};
    assign d2 = {1'b0, r_den, 1'b0};
    assign d3 = d1 + d2;

    always_comb begin
        if (part >= d3) begin
            digit = 2'd3;
            rem_full = part - d3;
        end else if (part >= d2) begin
            digit = 2'd2;
            rem_full = part - d2;
        end else if (part >= d1) begin
            digit = 2'd1;
            rem_full = part - d1;
        end else begin
            digit = 2'd0;
            rem_full = part;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt <= i_req.steps - 5'd1;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= rem_full[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-3:0], digit};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo = r_quo;

endmodule

### sv/auto_gearbox_shift_and_torque.sv
// automatic gearbox: gear selection and torque scaling, one word per tick
// depends on agst_pkg and agst_div
//
// Usage
//   input channel (i_in_valid / o_in_ready) takes one word: speed, direction,
//   raw acceleration. output channel (o_out_valid / i_out_ready) returns one
//   word per input: gear, gear top speed, scaled acceleration.
//   configuration channel (i_cfg_valid / o_cfg_ready) writes max speed
//   (index 0) or auto mode (index 1); only taken while no word is in work.
// Sequencing
//   a word is worked on by a sequencer around one multiplier and one radix-4
//   divider (two quotient bits per cycle). a word in reverse or with zero max
//   speed needs no division; the upshift check, the downshift check and the
//   lugging penalty each add divisions. one word is in work at a time;
//   o_in_ready is high only between words.
// Reset
//   max speed 0, auto mode on, first gear, no result pending.
// Stall
//   the result sits in an output register; a new word is accepted while it
//   waits, and the sequencer holds its next result until the register frees.
module auto_gearbox_shift_and_torque
    import agst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [15:0]    i_speed,
    input  logic signed [1:0]     i_direction,
    input  logic [15:0]           i_accel_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_gear,
    output logic [14:0]           o_gear_top_speed,
    output logic [16:0]           o_accel_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state;
    t_state n_state;

    logic [14:0]        r_max_speed;
    logic               r_auto_mode;
    logic [2:0]         r_gear;
    logic signed [15:0] r_spd;
    logic [1:0]         r_dir;
    logic [15:0]        r_acc;
    logic [14:0]        r_top;
    logic [14:0]        r_bottom;
    logic [23:0]        r_band;
    logic [16:0]        r_base;
    logic [19:0]        r_m;
    logic [26:0]        r_m99;
    logic [16:0]        r_res_acc;

    logic               r_out_valid;
    logic [2:0]         r_out_gear;
    logic [14:0]        r_out_top;
    logic [16:0]        r_out_acc;

    logic [26:0] mul_a;
    logic [23:0] mul_b;
    logic [50:0] mul_p;
    t_div_req    div_req;
    t_div_rsp    div_rsp;

    logic        in_acc;
    logic        out_free;
    logic [14:0] quo15;
    logic        spd_ge_quo;
    logic        spd_le_quo;
    logic        spd_le_zero;
    logic        rev_entry;
    logic        held;
    logic        spd_lt_bot;
    logic [15:0] spd_mag;
    logic [15:0] pos_raw;
    logic [14:0] range_w;
    logic [14:0] pos;
    logic [16:0] final_acc;

    agst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign mul_p = mul_a * mul_b;

    assign in_acc = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);

    assign quo15 = div_rsp.quo[14:0];
    assign spd_ge_quo = (r_spd >= $signed({1'b0, quo15}));
    assign spd_le_quo = (r_spd <= $signed({1'b0, quo15}));
    assign spd_le_zero = r_spd[15] || (r_spd == 16'sd0);
    assign rev_entry = r_spd[15] || (r_dir[1] && spd_le_zero);
    assign held = (r_max_speed == '0) || !r_auto_mode;
    assign spd_lt_bot = (r_spd < $signed({1'b0, r_bottom}));
    assign spd_mag = r_spd[15] ? (16'd0 - $unsigned(r_spd)) : $unsigned(r_spd);
    assign pos_raw = $unsigned(r_spd) - {1'b0, r_bottom};
    assign range_w = r_top - r_bottom;
    assign pos = (pos_raw[14:0] > range_w) ? range_w : pos_raw[14:0];

    always_comb begin
        if (div_rsp.quo == '0) begin
            final_acc = 17'd1;
        end else if (div_rsp.quo > DIV_NUM_W'(ACCEL_OUT_MAX)) begin
            final_acc = ACCEL_OUT_MAX;
        end else begin
            final_acc = div_rsp.quo[16:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_CHK;
            end
            ST_CHK: begin
                if (held || rev_entry || r_gear == GEAR_REV) begin
                    n_state = ST_TOP_MUL;
                end else if (r_dir == 2'b01 && r_gear < GEAR_TOP) begin
                    n_state = ST_UP_MUL;
                end else if (r_gear > GEAR_FIRST) begin
                    n_state = ST_DN_MUL;
                end else begin
                    n_state = ST_TOP_MUL;
                end
            end
            ST_UP_MUL: n_state = ST_UP_DIV;
            ST_UP_DIV: begin
                if (div_rsp.done) begin
                    n_state = (spd_ge_quo || r_gear > GEAR_FIRST) ? ST_DN_MUL : ST_TOP_MUL;
                end
            end
            ST_DN_MUL: n_state = ST_DN_DIV;
            ST_DN_DIV: begin
                if (div_rsp.done) n_state = ST_TOP_MUL;
            end
            ST_TOP_MUL: begin
                if (r_gear == GEAR_REV || r_max_speed == '0) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_TOP_DIV;
                end
            end
            ST_TOP_DIV: begin
                if (div_rsp.done) begin
                    n_state = (r_gear > GEAR_FIRST) ? ST_BOT_MUL : ST_BAND;
                end
            end
            ST_BOT_MUL: n_state = ST_BOT_DIV;
            ST_BOT_DIV: begin
                if (div_rsp.done) n_state = ST_BAND;
            end
            ST_BAND: begin
                if (spd_lt_bot) begin
                    n_state = (r_bottom != '0) ? ST_RAT_MUL : ST_BASE_MUL;
                end else begin
                    n_state = (range_w != '0) ? ST_LIN_MUL : ST_BASE_MUL;
                end
            end
            ST_RAT_MUL: n_state = ST_RAT_DIV;
            ST_RAT_DIV: begin
                if (div_rsp.done) n_state = ST_SQ_MUL;
            end
            ST_SQ_MUL:  n_state = ST_SQ2_MUL;
            ST_SQ2_MUL: n_state = ST_SQ_DIV;
            ST_SQ_DIV: begin
                if (div_rsp.done) n_state = ST_BASE_MUL;
            end
            ST_LIN_MUL: n_state = ST_LIN_DIV;
            ST_LIN_DIV: begin
                if (div_rsp.done) n_state = ST_BASE_MUL;
            end
            ST_BASE_MUL: n_state = ST_BASE_DIV;
            ST_BASE_DIV: begin
                if (div_rsp.done) n_state = ST_BB_MUL;
            end
            ST_BB_MUL: n_state = ST_BB_DIV;
            ST_BB_DIV: begin
                if (div_rsp.done) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // multiplier operands and divider requests
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        div_req = '0;
        div_req.num = mul_p[DIV_NUM_W-1:0];
        case (r_state)
            ST_UP_MUL: begin
                mul_a = {12'd0, r_max_speed};
                mul_b = {16'd0, f_up_pct(r_gear)};
                div_req.start = 1'b1;
                div_req.den = DEN_PCT;
                div_req.steps = STEPS_22B;
            end
            ST_DN_MUL: begin
                mul_a = {12'd0, r_max_speed};
                mul_b = {16'd0, f_down_pct(r_gear)};
                div_req.start = 1'b1;
                div_req.den = DEN_PCT;
                div_req.steps = STEPS_22B;
            end
            ST_TOP_MUL: begin
                mul_a = {12'd0, r_max_speed};
                mul_b = {16'd0, f_top_pct(r_gear)};
                div_req.start = (r_gear != GEAR_REV) && (r_max_speed != '0);
                div_req.den = DEN_PCT;
                div_req.steps = STEPS_22B;
            end
            ST_BOT_MUL: begin
                mul_a = {12'd0, r_max_speed};
                mul_b = {16'd0, f_top_pct(r_gear - 3'd1)};
                div_req.start = 1'b1;
                div_req.den = DEN_PCT;
                div_req.steps = STEPS_22B;
            end
            ST_RAT_MUL: begin
                // magnitude only: the ratio is squared afterwards
                mul_a = {11'd0, spd_mag};
                mul_b = {16'd0, PCT_SCALE};
                div_req.start = 1'b1;
                div_req.den = r_bottom;
                div_req.steps = STEPS_22B;
            end
            ST_SQ_MUL: begin
                mul_a = {7'd0, r_m};
                mul_b = {16'd0, LUG_GAIN};
            end
            ST_SQ2_MUL: begin
                mul_a = r_m99;
                mul_b = {4'd0, r_m};
                div_req.start = 1'b1;
                div_req.den = DEN_SQ;
                div_req.steps = (r_m <= RATIO_SMALL) ? STEPS_20B : STEPS_48B;
            end
            ST_LIN_MUL: begin
                mul_a = {12'd0, pos};
                mul_b = {16'd0, FALL_GAIN};
                div_req.start = 1'b1;
                div_req.den = range_w;
                div_req.steps = STEPS_22B;
            end
            ST_BASE_MUL: begin
                mul_a = {11'd0, r_acc};
                mul_b = {16'd0, f_torque_pct(r_gear)};
                div_req.start = 1'b1;
                div_req.den = DEN_PCT;
                div_req.steps = STEPS_24B;
            end
            ST_BB_MUL: begin
                mul_a = {10'd0, r_base};
                mul_b = r_band;
                div_req.start = 1'b1;
                div_req.den = DEN_PCT;
                div_req.steps = (r_band <= BAND_FULL) ? STEPS_24B : STEPS_42B;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // control: state, configuration, gear, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_max_speed <= '0;
            r_auto_mode <= 1'b1;
            r_gear <= GEAR_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_MAX_SPEED: r_max_speed <= i_cfg_data;
                    REG_AUTO_MODE: r_auto_mode <= i_cfg_data[0];
                    default: r_auto_mode <= r_auto_mode;
                endcase
            end
            case (r_state)
                ST_CHK: begin
                    if (!held) begin
                        if (rev_entry) begin
                            r_gear <= GEAR_REV;
                        end else if (r_gear == GEAR_REV && !r_dir[1]) begin
                            r_gear <= GEAR_FIRST;
                        end
                    end
                end
                ST_UP_DIV: begin
                    if (div_rsp.done && spd_ge_quo) r_gear <= r_gear + 3'd1;
                end
                ST_DN_DIV: begin
                    if (div_rsp.done && spd_le_quo) r_gear <= r_gear - 3'd1;
                end
                default: r_gear <= r_gear;
            endcase
            if (r_state == ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_spd <= i_speed;
            r_dir <= i_direction;
            r_acc <= i_accel_in;
        end
        case (r_state)
            ST_TOP_MUL: begin
                r_top <= r_max_speed;
                r_res_acc <= {1'b0, r_acc};
            end
            ST_TOP_DIV: begin
                if (div_rsp.done) begin
                    r_top <= quo15;
                    r_bottom <= '0;
                end
            end
            ST_BOT_DIV: begin
                if (div_rsp.done) r_bottom <= quo15;
            end
            ST_BAND: begin
                r_band <= BAND_FULL;
            end
            ST_RAT_DIV: begin
                if (div_rsp.done) begin
                    r_m <= (|div_rsp.quo[DIV_NUM_W-1:20]) ? RATIO_MAX : div_rsp.quo[19:0];
                end
            end
            ST_SQ_MUL: begin
                r_m99 <= mul_p[26:0];
            end
            ST_SQ_DIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.quo >= DIV_NUM_W'(BAND_MAX)) begin
                        r_band <= BAND_MAX;
                    end else begin
                        r_band <= div_rsp.quo[23:0] + 24'd1;
                    end
                end
            end
            ST_LIN_DIV: begin
                if (div_rsp.done) r_band <= BAND_FULL - div_rsp.quo[23:0];
            end
            ST_BASE_DIV: begin
                if (div_rsp.done) r_base <= div_rsp.quo[16:0];
            end
            ST_BB_DIV: begin
                if (div_rsp.done) r_res_acc <= final_acc;
            end
            ST_FIN: begin
                if (out_free) begin
                    r_out_gear <= r_gear;
                    r_out_top <= r_top;
                    r_out_acc <= r_res_acc;
                end
            end
            default: r_base <= r_base;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_gear = r_out_gear;
    assign o_gear_top_speed = r_out_top;
    assign o_accel_out = r_out_acc;

    a_gear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gear <= GEAR_TOP)
        else $error("gear out of range");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !div_rsp.busy)
        else $error("divider busy while between words");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_UP_DIV || r_state == ST_DN_DIV ||
                          r_state == ST_TOP_DIV || r_state == ST_BOT_DIV ||
                          r_state == ST_RAT_DIV || r_state == ST_SQ_DIV ||
                          r_state == ST_LIN_DIV || r_state == ST_BASE_DIV ||
                          r_state == ST_BB_DIV))
        else $error("quotient arrived outside a division wait");

    a_manual_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHK && held) |=> $stable(r_gear))
        else $error("gear moved while shifting is disabled");

    a_acc_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_accel_out <= ACCEL_OUT_MAX))
        else $error("scaled acceleration above limit");

endmodule

### dv/gearbox_checker.sv
// watches the gearbox channels, predicts gear, top speed and scaled acceleration
// per word and compares them with the results; depends on agst_pkg
module gearbox_checker
    import agst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic signed [15:0]    i_speed,
    input  logic signed [1:0]     i_direction,
    input  logic [15:0]           i_accel_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [2:0]            i_gear,
    input  logic [14:0]           i_gear_top_speed,
    input  logic [16:0]           i_accel_out,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_ticks_checked,
    output logic [5:0]            o_gears_seen
);

    typedef struct packed {
        logic [2:0]  gear;
        logic [14:0] top_speed;
        logic [16:0] accel;
    } t_tick_result;

    // percent tables, element 0 is first gear
    localparam logic [4:0][7:0] TOP_PCT    = {8'd100, 8'd80, 8'd60, 8'd40, 8'd22};
    localparam logic [4:0][7:0] TORQUE_PCT = {8'd55, 8'd75, 8'd100, 8'd130, 8'd160};
    localparam logic [4:0][7:0] UP_PCT     = {8'd100, 8'd76, 8'd57, 8'd38, 8'd20};
    localparam logic [4:0][7:0] DOWN_PCT   = {8'd52, 8'd35, 8'd18, 8'd8, 8'd0};
    localparam longint ACCEL_CEIL = 104856;

    logic [14:0]  max_spd;
    logic         auto_on;
    logic [2:0]   gear_q;
    t_tick_result expected_ticks[$];

    function automatic longint share_of_max(input logic [7:0] pct);
        return longint'(max_spd) * longint'(pct) / 100;
    endfunction

    // one tick: shift decision first, then torque and power band on the new gear
    function automatic t_tick_result run_tick(input longint spd, input longint dir,
                                              input longint acc);
        t_tick_result r;
        longint g, bottom, ceiling, span, band, base, ratio, pos;
        g = gear_q;
        if (max_spd != 0 && auto_on) begin
            if (spd < 0 || (dir < 0 && spd <= 0)) begin
                g = 0;
            end else if (g == 0) begin
                if (dir >= 0) g = 1;
            end else begin
                if (dir > 0 && g < 5 && spd >= share_of_max(UP_PCT[g-1])) g++;
                if (g > 1 && spd <= share_of_max(DOWN_PCT[g-1])) g--;
            end
        end
        ceiling = (g >= 1) ? share_of_max(TOP_PCT[g-1]) : longint'(max_spd);
        if (max_spd == 0 || g == 0) begin
            base = acc;
        end else begin
            bottom = (g > 1) ? share_of_max(TOP_PCT[g-2]) : 0;
            span = ceiling - bottom;
            if (spd < bottom) begin
                if (bottom > 0) begin
                    // lugging penalty, quadratic in the ratio to the gear bottom
                    ratio = spd * 100 / bottom;
                    band = 1 + (99 * ratio * ratio / 10000);
                end else begin
                    band = 100;
                end
            end else begin
                pos = spd - bottom;
                if (pos > span) pos = span;
                band = (span > 0) ? 100 - (45 * pos / span) : 100;
            end
            base = acc * longint'(TORQUE_PCT[g-1]) / 100;
            base = base * band / 100;
            if (base < 1) base = 1;
            if (base > ACCEL_CEIL) base = ACCEL_CEIL;
        end
        r.gear = g[2:0];
        r.top_speed = ceiling[14:0];
        r.accel = base[16:0];
        return r;
    endfunction

    task automatic note_failure(input string what, input t_tick_result want,
                                input t_tick_result got);
        if (o_mismatches < 10) begin
            $display("%0t: %s: gear %0d/%0d top speed %0d/%0d accel %0d/%0d (expected/actual)",
                     $realtime, what, want.gear, got.gear, want.top_speed, got.top_speed,
                     want.accel, got.accel);
        end
        o_mismatches++;
    endtask

    initial begin
        o_mismatches = 0;
        o_pending = 0;
        o_ticks_checked = 0;
        o_gears_seen = '0;
    end

    always @(posedge i_clk) begin : watch
        t_tick_result want, got;
        if (!i_rst_n) begin
            max_spd = '0;
            auto_on = 1'b1;
            gear_q = GEAR_FIRST;
            expected_ticks.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MAX_SPEED: max_spd = i_cfg_data;
                    REG_AUTO_MODE: auto_on = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_gear, i_gear_top_speed, i_accel_out};
                if (expected_ticks.size() == 0) begin
                    note_failure("result with no word pending", '0, got);
                end else begin
                    want = expected_ticks.pop_front();
                    if (got.gear !== want.gear || got.top_speed !== want.top_speed ||
                        got.accel !== want.accel) begin
                        note_failure("result mismatch", want, got);
                    end
                    if (got.gear <= GEAR_TOP) o_gears_seen[got.gear] = 1'b1;
                    o_ticks_checked++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = run_tick(longint'(i_speed), longint'(i_direction),
                                longint'(i_accel_in));
                gear_q = want.gear;
                expected_ticks.push_back(want);
            end
        end
        o_pending = expected_ticks.size();
    end

endmodule

### dv/auto_gearbox_shift_and_torque_tb.sv
// stimulus and verdict for auto_gearbox_shift_and_torque
// depends on agst_pkg, the block itself and gearbox_checker
module auto_gearbox_shift_and_torque_tb;
    import agst_pkg::*;

    localparam int PERIOD = 12;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 160;
    localparam int LONG_HOLD = 600;
    localparam int PHASES = 10;
    localparam int WORDS_PER_PHASE = 98;

    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_FWD = 2'b01;
    localparam logic [1:0] DIR_ODD = 2'b10;   // -2, taken as a reverse request
    localparam logic [1:0] DIR_REV = 2'b11;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic signed [15:0]    speed = '0;
    logic signed [1:0]     direction = '0;
    logic [15:0]           accel_in = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [2:0]            gear;
    logic [14:0]           gear_top_speed;
    logic [16:0]           accel_out;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int         mismatches, pending, ticks_checked;
    logic [5:0] gears_seen;

    bit no_gaps = 1'b0;
    int stalls_asked = 0;
    int stalls_done = 0;
    int words_sent = 0;
    int settings_used = 0;
    int road_speed = 0;

    auto_gearbox_shift_and_torque i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_speed(speed), .i_direction(direction), .i_accel_in(accel_in),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_gear(gear), .o_gear_top_speed(gear_top_speed), .o_accel_out(accel_out),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    gearbox_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_speed(speed), .i_direction(direction), .i_accel_in(accel_in),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_gear(gear), .i_gear_top_speed(gear_top_speed), .i_accel_out(accel_out),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_mismatches(mismatches), .o_pending(pending),
        .o_ticks_checked(ticks_checked), .o_gears_seen(gears_seen)
    );

    always #(PERIOD / 2) clk = ~clk;

    initial begin
        #(LIMIT_CYCLES * PERIOD);
        $display("TEST FAILED");
        $finish;
    end

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 8);
    endfunction

    // result side: random hold-off per word, plus one long stall on request
    initial begin : receiver
        int hold;
        forever begin
            hold = draw_gap();
            if (stalls_asked != stalls_done) begin
                hold += LONG_HOLD;
                stalls_done++;
            end
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic send_word(input logic [15:0] spd, input logic [1:0] dir,
                             input logic [15:0] acc);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        speed <= spd;
        direction <= dir;
        accel_in <= acc;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // both registers in one burst, valid held high between the two writes
    task automatic configure(input logic [14:0] ms, input logic auto_on);
        go_idle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_MAX_SPEED;
        cfg_data <= ms;
        for (int k = 0; k < 2; k++) begin
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            @(negedge clk);
            if (k == 0) begin
                cfg_index <= REG_AUTO_MODE;
                cfg_data <= {14'd0, auto_on};
            end
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // mostly a plausible drive cycle around the configured max speed, some noise
    task automatic random_word(input int ms);
        logic [15:0] spd, acc;
        logic [1:0]  dir;
        int roll, step, upper, lower;
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
            spd = 16'($urandom_range(0, 65535));
            dir = 2'($urandom_range(0, 3));
            acc = 16'($urandom_range(0, 65535));
        end else begin
            roll = $urandom_range(0, 99);
            dir = (roll < 78) ? DIR_FWD : (roll < 88) ? DIR_NONE : DIR_REV;
            step = $urandom_range(0, ms / 5 + 2);
            case (dir)
                DIR_FWD: road_speed += ($urandom_range(0, 3) != 0) ? step : -step;
                DIR_NONE: road_speed -= step / 2;
                default: road_speed -= step;
            endcase
            upper = ms + ms / 8 + 2;
            lower = -(ms / 4) - 2;
            if (upper > 32767) upper = 32767;
            if (lower < -32768) lower = -32768;
            if (road_speed > upper) road_speed = upper;
            if (road_speed < lower) road_speed = lower;
            spd = road_speed[15:0];
            roll = $urandom_range(0, 9);
            acc = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        end
        send_word(spd, dir, acc);
    endtask

    initial begin : stimulus
        logic [14:0] ms;
        logic        auto_on;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero max speed after reset: gear held, acceleration passed through
        send_word(16'h7FFF, DIR_FWD, 16'hFFFF);
        send_word(16'h8000, DIR_REV, 16'h0000);
        send_word(16'h0000, DIR_NONE, 16'h0001);

        // climb to fifth, then top of band
        configure(15'd1000, 1'b1);
        repeat (5) send_word(16'd1000, DIR_FWD, 16'hFFFF);
        // reverse entry, stay in reverse while moving back, exit to first
        send_word(16'd0, DIR_REV, 16'd1000);
        send_word(-16'sd200, DIR_NONE, 16'd500);
        send_word(16'd300, DIR_NONE, 16'd500);
        // zero acceleration clamps to one
        send_word(16'd10, DIR_FWD, 16'd0);
        send_word(16'd450, DIR_FWD, 16'd40000);
        // lugging below the second gear bottom, then downshift on coasting
        send_word(16'd100, DIR_FWD, 16'd40000);
        send_word(16'd50, DIR_NONE, 16'd40000);
        send_word(16'd450, DIR_FWD, 16'd40000);

        // manual: held gear, deep negative lugging saturates the output
        configure(15'd1000, 1'b0);
        send_word(16'h8000, DIR_FWD, 16'hFFFF);
        send_word(16'd700, DIR_ODD, 16'd30000);

        configure(15'd1000, 1'b1);
        send_word(16'd0, DIR_ODD, 16'd30000);

        configure(15'h7FFF, 1'b1);
        send_word(16'h7FFF, DIR_FWD, 16'hFFFF);
        send_word(16'h7FFF, DIR_FWD, 16'hFFFF);

        // max speed of one: every threshold below the full max speed truncates to zero
        configure(15'd1, 1'b1);
        send_word(16'd1, DIR_FWD, 16'hFFFF);
        send_word(16'd0, DIR_NONE, 16'hFFFF);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: ms = 15'h7FFF;
                1: ms = 15'd1;
                2: ms = 15'd0;
                3: ms = 15'($urandom_range(500, 3000));
                default: ms = $urandom_range(0, 1) ? 15'($urandom_range(2, 32767))
                                                   : 15'($urandom_range(50, 3000));
            endcase
            auto_on = (p == 3 || p == 7) ? 1'b0 : 1'b1;
            configure(ms, auto_on);
            road_speed = 0;
            // phase 4 stalls the result side while words keep coming,
            // phase 5 runs back to back on both sides
            no_gaps = (p == 4 || p == 5);
            if (p == 4) stalls_asked++;
            repeat (WORDS_PER_PHASE) random_word(int'(ms));
        end
        no_gaps = 1'b0;

        go_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d words sent over %0d register settings, %0d results checked",
                 words_sent, settings_used, ticks_checked);
        $display("gears reported (5th..reverse) %b, %0d mismatching results",
                 gears_seen, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### files.f
sv/agst_pkg.sv
sv/agst_div.sv
sv/auto_gearbox_shift_and_torque.sv
dv/gearbox_checker.sv
dv/auto_gearbox_shift_and_torque_tb.sv
